// ----- sv/fpp_pkg.sv -----
`timescale 1ns / 1ps

package fpp_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;

    localparam int BLK_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CFG_W  = 5;
    localparam int K_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int OP_W   = 2;
    localparam int POL_W  = 2;
    localparam int IDX_W  = 4;
    localparam int SIZE_W = 16;
    localparam int CIDX_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_NEXT  = 2'd2;
    localparam logic [POL_W-1:0] POL_NONE  = 2'd3;

    localparam logic [CIDX_W-1:0] REG_POLICY     = 2'd0;
    localparam logic [CIDX_W-1:0] REG_NUM_BLOCKS = 2'd1;
    localparam logic [CIDX_W-1:0] REG_START_POS  = 2'd2;

    typedef struct packed {
        logic load;
        logic clear;
        logic start;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- sv/fixed_partition_placement.sv -----
`timescale 1ns / 1ps

// Fixed-partition placement: load, clear and place transactions on the input
// channel; each place transaction returns one result (granted, block, leftover)
// through an output register. Load and clear are applied when accepted and
// leave the channel ready. A place registers its request, then runs the
// single-comparator scan, one partition per cycle, over at least one slot,
// even when no partition is in range, and at most the partition count, and
// then registers its result. Best fit always scans the whole table, first and
// next fit stop at the first fit. A result still held in the output register
// keeps the place in its last cycle until the receiver takes it, and no new
// transaction is accepted meanwhile. Configuration writes are accepted every
// cycle but belong in idle periods.
module fixed_partition_placement (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [fpp_pkg::OP_W-1:0]       i_op,
    input  logic [fpp_pkg::IDX_W-1:0]      i_block_index,
    input  logic [fpp_pkg::SIZE_W-1:0]     i_size,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_granted,
    output logic [fpp_pkg::IDX_W-1:0]      o_chosen_block,
    output logic [fpp_pkg::SIZE_W-1:0]     o_leftover,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fpp_pkg::CIDX_W-1:0]     i_cfg_index,
    input  logic [fpp_pkg::CFG_W-1:0]      i_cfg_data
);

    fpp_pkg::t_dp_cmd    w_cmd;
    fpp_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    fpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fpp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_block_index  (i_block_index),
        .i_size         (i_size),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_granted      (o_granted),
        .o_chosen_block (o_chosen_block),
        .o_leftover     (o_leftover)
    );

endmodule

// ----- sv/fpp_ctrl.sv -----
`timescale 1ns / 1ps

module fpp_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [fpp_pkg::OP_W-1:0]     i_op,
    output logic                         o_in_ready,
    input  fpp_pkg::t_dp_status          i_status,
    output fpp_pkg::t_dp_cmd             o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.load   = w_accept && (i_op == fpp_pkg::OP_LOAD);
        o_cmd.clear  = w_accept && (i_op == fpp_pkg::OP_CLEAR);
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_op == fpp_pkg::OP_PLACE)) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/fpp_dp.sv -----
`timescale 1ns / 1ps

module fpp_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fpp_pkg::t_dp_cmd               i_cmd,
    output fpp_pkg::t_dp_status            o_status,
    input  logic [fpp_pkg::IDX_W-1:0]      i_block_index,
    input  logic [fpp_pkg::SIZE_W-1:0]     i_size,
    input  logic                           i_cfg_we,
    input  logic [fpp_pkg::CIDX_W-1:0]     i_cfg_index,
    input  logic [fpp_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_granted,
    output logic [fpp_pkg::IDX_W-1:0]      o_chosen_block,
    output logic [fpp_pkg::SIZE_W-1:0]     o_leftover
);

    logic [fpp_pkg::POL_W-1:0]      r_policy;
    logic [fpp_pkg::CFG_W-1:0]      r_num_blocks;
    logic [fpp_pkg::CFG_W-1:0]      r_start;
    logic [fpp_pkg::K_W-1:0]        r_rover;

    logic [fpp_pkg::SIZE_BITS-1:0]  r_sizes [fpp_pkg::MAX_BLOCKS];
    logic [fpp_pkg::MAX_BLOCKS-1:0] r_used;

    logic [fpp_pkg::K_W-1:0]        r_k;
    logic [fpp_pkg::SIZE_BITS-1:0]  r_req;
    logic                           r_have;
    logic [fpp_pkg::BLK_W-1:0]      r_pick;
    logic [fpp_pkg::SIZE_BITS-1:0]  r_best;

    logic                           r_out_valid;
    logic                           r_granted;
    logic [fpp_pkg::IDX_W-1:0]      r_chosen;
    logic [fpp_pkg::SIZE_W-1:0]     r_leftover;

    logic [fpp_pkg::K_W-1:0]        w_count;
    logic [fpp_pkg::K_W:0]          w_k_next;
    logic                           w_in_range;
    logic [fpp_pkg::BLK_W-1:0]      w_slot;
    logic [fpp_pkg::SIZE_BITS-1:0]  w_rd;
    logic [fpp_pkg::SIZE_BITS-1:0]  w_left;
    logic                           w_fits;
    logic                           w_take;
    logic [fpp_pkg::K_W-1:0]        n_rover;

    // a partition count beyond the table counts as the table size
    assign w_count = (int'(r_num_blocks) > fpp_pkg::MAX_BLOCKS)
                     ? fpp_pkg::K_W'(fpp_pkg::MAX_BLOCKS)
                     : fpp_pkg::K_W'(r_num_blocks);

    assign w_slot     = r_k[fpp_pkg::BLK_W-1:0];
    assign w_in_range = (r_k < w_count);
    assign w_rd       = r_sizes[w_slot];
    assign w_left     = w_rd - r_req;
    assign w_fits     = w_in_range && !r_used[w_slot] && (w_rd >= r_req);
    assign w_take     = w_fits && (r_policy != fpp_pkg::POL_NONE)
                        && (!r_have || (w_left < r_best));
    assign w_k_next   = {1'b0, r_k} + (fpp_pkg::K_W + 1)'(1);

    assign o_status.scan_last = !w_in_range
                                || (r_policy == fpp_pkg::POL_NONE)
                                || (w_fits && (r_policy != fpp_pkg::POL_BEST))
                                || (w_k_next >= {1'b0, w_count});
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign n_rover = r_have ? (fpp_pkg::K_W'(r_pick) + fpp_pkg::K_W'(1)) : w_count;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= fpp_pkg::POL_BEST;
            r_num_blocks <= fpp_pkg::CFG_W'(16);
            r_start      <= '0;
            r_rover      <= '0;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
            r_have       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fpp_pkg::REG_POLICY:     r_policy <= i_cfg_data[fpp_pkg::POL_W-1:0];
                    fpp_pkg::REG_NUM_BLOCKS: r_num_blocks <= i_cfg_data;
                    fpp_pkg::REG_START_POS: begin
                        r_start <= i_cfg_data;
                        r_rover <= fpp_pkg::K_W'(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clear) begin
                r_used  <= '0;
                r_rover <= fpp_pkg::K_W'(r_start);
            end
            if (i_cmd.start) begin
                r_have <= 1'b0;
            end
            if (i_cmd.step && w_take) begin
                r_have <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_have) begin
                    r_used[r_pick] <= 1'b1;
                end
                if (r_policy == fpp_pkg::POL_NEXT) begin
                    r_rover <= n_rover;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (int'(i_block_index) < fpp_pkg::MAX_BLOCKS)) begin
            r_sizes[fpp_pkg::BLK_W'(i_block_index)] <= fpp_pkg::SIZE_BITS'(i_size);
        end
        if (i_cmd.start) begin
            r_req <= fpp_pkg::SIZE_BITS'(i_size);
            r_k   <= (r_policy == fpp_pkg::POL_NEXT) ? r_rover : '0;
        end
        if (i_cmd.step) begin
            r_k <= w_k_next[fpp_pkg::K_W-1:0];
            if (w_take) begin
                r_pick <= w_slot;
                r_best <= w_left;
            end
        end
        if (i_cmd.commit) begin
            r_granted  <= r_have;
            r_chosen   <= r_have ? fpp_pkg::IDX_W'(r_pick) : '0;
            r_leftover <= r_have ? fpp_pkg::SIZE_W'(r_best) : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted      = r_granted;
    assign o_chosen_block = r_chosen;
    assign o_leftover     = r_leftover;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import fpp_pkg::*;

    localparam logic [OP_W-1:0]   OP_NOP      = 2'd3;
    localparam logic [CIDX_W-1:0] REG_SPARE   = 2'd3;
    localparam int                CYCLE_LIMIT = 500000;
    localparam int                SETTLE      = 24;
    localparam int                HOLD_CYCLES = 300;
    localparam int                N_DIRECTED  = 30;
    localparam int                N_PHASES    = 12;

    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  blk;
        logic [SIZE_W-1:0] leftover;
    } placement_t;

    typedef struct packed {
        logic              is_cfg;
        logic [CIDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]  reg_val;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] sz;
        logic              typed;
        placement_t        want;
    } directed_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_op;
    logic [IDX_W-1:0]  i_block_index;
    logic [SIZE_W-1:0] i_size;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_granted;
    logic [IDX_W-1:0]  o_chosen_block;
    logic [SIZE_W-1:0] o_leftover;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    // predicted block state and settings
    logic [SIZE_W-1:0] part_size [MAX_BLOCKS];
    logic              part_used [MAX_BLOCKS];
    int                rover       = 0;
    logic [POL_W-1:0]  cur_policy  = POL_BEST;
    logic [CFG_W-1:0]  cur_nblocks = 5'd16;
    logic [CFG_W-1:0]  cur_start   = 5'd0;

    placement_t    expected_placements [$];
    directed_row_t directed_rows [N_DIRECTED];

    logic [POL_W-1:0] phase_policy [N_PHASES] = '{POL_FIRST, POL_BEST, POL_NEXT, POL_FIRST,
                                                  POL_NEXT, POL_BEST, POL_NEXT, POL_NONE,
                                                  POL_BEST, POL_FIRST, POL_NEXT, POL_NEXT};
    int phase_blocks [N_PHASES] = '{16, 16, 16, 31, 16, 0, 1, 16, 20, 2, 16, 16};
    int phase_start  [N_PHASES] = '{16, 0, 0, 31, 3, 0, 0, 0, 31, 0, -1, 1};
    int phase_items  [N_PHASES] = '{100, 100, 100, 100, 100, 40, 100, 30, 100, 100, 100, 100};

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;
    int cycle_count  = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int grants_seen  = 0;
    int failures     = 0;

    fixed_partition_placement dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_block_index  (i_block_index),
        .i_size         (i_size),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_granted      (o_granted),
        .o_chosen_block (o_chosen_block),
        .o_leftover     (o_leftover),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic directed_row_t cfg_row(logic [CIDX_W-1:0] r, logic [CFG_W-1:0] v);
        cfg_row         = '0;
        cfg_row.is_cfg  = 1'b1;
        cfg_row.reg_idx = r;
        cfg_row.reg_val = v;
    endfunction

    function automatic directed_row_t item_row(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                               logic [SIZE_W-1:0] sz);
        item_row     = '0;
        item_row.op  = op;
        item_row.idx = idx;
        item_row.sz  = sz;
    endfunction

    function automatic directed_row_t typed_row(logic [SIZE_W-1:0] sz, logic g,
                                                logic [IDX_W-1:0] b, logic [SIZE_W-1:0] l);
        typed_row                   = item_row(OP_PLACE, '0, sz);
        typed_row.typed             = 1'b1;
        typed_row.want.granted      = g;
        typed_row.want.blk          = b;
        typed_row.want.leftover     = l;
    endfunction

    task automatic predict_placement(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                     input logic [SIZE_W-1:0] sz, output logic has_res,
                                     output placement_t res);
        int                n;
        int                from;
        int                pick;
        logic              ok;
        logic [SIZE_W-1:0] best_left;
        n         = (int'(cur_nblocks) > MAX_BLOCKS) ? MAX_BLOCKS : int'(cur_nblocks);
        pick      = 0;
        ok        = 1'b0;
        best_left = '0;
        has_res   = 1'b0;
        res       = '0;
        case (op)
            OP_LOAD: part_size[idx] = sz;
            OP_CLEAR: begin
                part_used = '{default: 1'b0};
                rover     = int'(cur_start);
            end
            OP_PLACE: begin
                has_res = 1'b1;
                if (cur_policy == POL_FIRST || cur_policy == POL_NEXT) begin
                    from = (cur_policy == POL_NEXT) ? rover : 0;
                    for (int k = from; k < n && !ok; k++) begin
                        if (!part_used[k] && part_size[k] >= sz) begin
                            ok   = 1'b1;
                            pick = k;
                        end
                    end
                    if (cur_policy == POL_NEXT)
                        rover = ok ? pick + 1 : n;
                end else if (cur_policy == POL_BEST) begin
                    for (int k = 0; k < n; k++) begin
                        if (!part_used[k] && part_size[k] >= sz
                                && (!ok || part_size[k] - sz < best_left)) begin
                            ok        = 1'b1;
                            best_left = part_size[k] - sz;
                            pick      = k;
                        end
                    end
                end
                if (ok) begin
                    part_used[pick] = 1'b1;
                    res.granted     = 1'b1;
                    res.blk         = IDX_W'(pick);
                    res.leftover    = part_size[pick] - sz;
                end
            end
            default: ;
        endcase
    endtask

    task automatic offer_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [SIZE_W-1:0] sz, input logic typed,
                              input placement_t want);
        logic       has_res;
        placement_t res;
        while (int'($urandom_range(99)) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_block_index <= idx;
        i_size        <= sz;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_placement(op, idx, sz, has_res, res);
        if (has_res)
            expected_placements.push_back(typed ? want : res);
        items_sent++;
    endtask

    // leaves the write valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CIDX_W-1:0] r, input logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (r)
            REG_POLICY:     cur_policy  = v[POL_W-1:0];
            REG_NUM_BLOCKS: cur_nblocks = v;
            REG_START_POS: begin
                cur_start = v;
                rover     = int'(v);
            end
            default: ;
        endcase
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_placements.size() != 0) @(posedge i_clk);
    endtask

    task automatic drain_to_idle();
        wait_for_results();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic check_placement();
        placement_t want;
        results_seen++;
        if (o_granted)
            grants_seen++;
        if (expected_placements.size() == 0) begin
            $display("%0t: unexpected result: granted %0b block %0d leftover %0d",
                     $time, o_granted, o_chosen_block, o_leftover);
            failures++;
        end else begin
            want = expected_placements.pop_front();
            if (o_granted !== want.granted) begin
                $display("%0t: granted expected %0b actual %0b", $time, want.granted, o_granted);
                failures++;
            end
            if (o_chosen_block !== want.blk) begin
                $display("%0t: chosen_block expected %0d actual %0d",
                         $time, want.blk, o_chosen_block);
                failures++;
            end
            if (o_leftover !== want.leftover) begin
                $display("%0t: leftover expected %0d actual %0d",
                         $time, want.leftover, o_leftover);
                failures++;
            end
        end
    endtask

    // result side: checks, random stalls and the long hold-off
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                check_placement();
            if (rx_hold_req) begin
                hold_left   = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (int'($urandom_range(99)) >= rx_stall_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        directed_row_t     row;
        logic              prev_cfg;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] sz;
        int                r;
        int                d;
        int                k;
        int                sp;
        int                mode;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = OP_LOAD;
        i_block_index = '0;
        i_size        = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_POLICY;
        i_cfg_data    = '0;
        part_size     = '{default: '0};
        part_used     = '{default: 1'b0};

        directed_rows = '{
            cfg_row(REG_NUM_BLOCKS, 5'd4),
            item_row(OP_LOAD, 4'd0, 16'hFFFF),
            item_row(OP_LOAD, 4'd1, 16'd0),
            item_row(OP_LOAD, 4'd2, 16'd100),
            item_row(OP_LOAD, 4'd3, 16'd50),
            typed_row(16'd40, 1'b1, 4'd3, 16'd10),
            item_row(OP_PLACE, 4'd0, 16'd0),
            typed_row(16'hFFFF, 1'b1, 4'd0, 16'd0),
            item_row(OP_PLACE, 4'd9, 16'd101),
            item_row(OP_CLEAR, 4'd5, 16'd7),
            cfg_row(REG_POLICY, CFG_W'(POL_FIRST)),
            typed_row(16'd0, 1'b1, 4'd0, 16'hFFFF),
            item_row(OP_PLACE, 4'd15, 16'd60),
            cfg_row(REG_POLICY, CFG_W'(POL_NEXT)),
            cfg_row(REG_START_POS, 5'd2),
            item_row(OP_PLACE, 4'd0, 16'd10),
            item_row(OP_PLACE, 4'd0, 16'd0),
            item_row(OP_CLEAR, 4'd0, 16'd0),
            item_row(OP_PLACE, 4'd0, 16'd200),
            item_row(OP_PLACE, 4'd0, 16'd0),
            cfg_row(REG_START_POS, 5'd16),
            typed_row(16'd0, 1'b0, 4'd0, 16'd0),
            cfg_row(REG_POLICY, CFG_W'(POL_NONE)),
            typed_row(16'd0, 1'b0, 4'd0, 16'd0),
            item_row(OP_NOP, 4'd15, 16'hFFFF),
            cfg_row(REG_SPARE, 5'd31),
            cfg_row(REG_NUM_BLOCKS, 5'd0),
            cfg_row(REG_POLICY, CFG_W'(POL_FIRST)),
            typed_row(16'd0, 1'b0, 4'd0, 16'd0),
            cfg_row(REG_NUM_BLOCKS, 5'd4)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                if (!prev_cfg)
                    drain_to_idle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                if (prev_cfg)
                    i_cfg_valid <= 1'b0;
                offer_item(row.op, row.idx, row.sz, row.typed, row.want);
            end
            prev_cfg = row.is_cfg;
        end
        if (prev_cfg)
            i_cfg_valid <= 1'b0;

        // every partition gets a size before the full table is searched
        for (int b = 0; b < MAX_BLOCKS; b++)
            offer_item(OP_LOAD, IDX_W'(b), SIZE_W'($urandom), 1'b0, '0);

        for (int p = 0; p < N_PHASES; p++) begin
            sp = (phase_start[p] < 0) ? int'($urandom_range(16)) : phase_start[p];
            drain_to_idle();
            write_reg(REG_POLICY, CFG_W'(phase_policy[p]));
            write_reg(REG_NUM_BLOCKS, CFG_W'(phase_blocks[p]));
            write_reg(REG_START_POS, CFG_W'(sp));
            i_cfg_valid <= 1'b0;
            mode         = p % 4;
            tx_idle_pct  = (mode == 1) ? 51 : (mode == 3) ? 15 : 0;
            rx_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 15 : 0;

            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 4 && n == 30)
                    rx_hold_req = 1'b1;
                if (p == 4 && n == 70)
                    wait_for_results();
                r   = int'($urandom_range(99));
                d   = int'($urandom_range(99));
                k   = int'($urandom_range(MAX_BLOCKS - 1));
                idx = IDX_W'($urandom_range(MAX_BLOCKS - 1));
                if (r < 62) begin
                    // requests mostly sized around the partitions actually held
                    op = OP_PLACE;
                    if (d < 40)
                        sz = (part_size[k] > SIZE_W'(3))
                            ? part_size[k] - SIZE_W'($urandom_range(3)) : part_size[k];
                    else if (d < 60)
                        sz = (part_size[k] == {SIZE_W{1'b1}})
                            ? part_size[k] : part_size[k] + SIZE_W'(1);
                    else if (d < 85)
                        sz = SIZE_W'($urandom);
                    else
                        sz = ($urandom_range(1) != 0) ? {SIZE_W{1'b1}} : '0;
                end else if (r < 84) begin
                    op = OP_LOAD;
                    if (d < 30)
                        sz = SIZE_W'($urandom_range(15));
                    else if (d < 70)
                        sz = SIZE_W'($urandom);
                    else if (d < 85)
                        sz = ($urandom_range(1) != 0) ? {SIZE_W{1'b1}} : '0;
                    else
                        sz = part_size[k];
                end else if (r < 95) begin
                    op = OP_CLEAR;
                    sz = SIZE_W'($urandom);
                end else begin
                    op = OP_NOP;
                    sz = SIZE_W'($urandom);
                end
                offer_item(op, idx, sz, 1'b0, '0);
            end
        end

        drain_to_idle();
        $display("%0d input transactions in %0d setting phases, %0d placement results, %0d granted",
                 items_sent, N_PHASES + 1, results_seen, grants_seen);
        $display("first, best, next and undefined policies, table sizes 0 to 31, long back-pressure");
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- fixed_partition_placement.f -----
sv/fpp_pkg.sv
sv/fpp_ctrl.sv
sv/fpp_dp.sv
sv/fixed_partition_placement.sv
verif/tb.sv
